// ===== hdl/ept_pkg.sv =====
package ept_pkg;

	// timer and averaging setup
	localparam int TIMER_SPAN = 65536;
	localparam int AVG_LEN    = 6;

	// field and state widths
	localparam int OP_W    = 2;
	localparam int CAP_W   = 16;
	localparam int LIMIT_W = 20;
	localparam int RUN_W   = 21;
	localparam int PER_W   = 22;
	localparam int SUM_W   = 24;
	localparam int POS_W   = 32;
	localparam int CNT_W   = $clog2(AVG_LEN + 1);

	localparam logic [LIMIT_W-1:0] STOP_LIMIT_RESET = LIMIT_W'(1000000);

	// sum limits, signed, SUM_W bits
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// divide by AVG_LEN as multiply by rounded-up reciprocal, exact for SUM_W-bit magnitudes
	localparam int    MAG_W = SUM_W + 1;
	localparam int    DIV_K = SUM_W + $clog2(AVG_LEN);
	localparam int    PROD_W = MAG_W + DIV_K + 1;
	localparam longint RECIP = ((longint'(1) << DIV_K) + longint'(AVG_LEN) - 1) / AVG_LEN;

	// stream word layout
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_OVERFLOW = 2'd0,
		OP_CAPTURE  = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CAP_W-1:0] capture_value;
		logic             forward;
	} item_t;

	typedef struct packed {
		logic signed [PER_W-1:0] period;
		logic signed [PER_W-1:0] average_period;
		logic                    average_new;
		logic signed [POS_W-1:0] position;
	} result_t;

endpackage

// ===== hdl/encoder_period_tachometer_core.sv =====
// Encoder period tachometer, one wheel.
// Input stream (s_*): one word per event. s_tuser carries the op code
// (timer overflow, encoder edge capture, position read-and-clear); s_tdata
// carries the captured timer value and the direction bit.
// Output stream (m_*): exactly one word per input word, in order: latest
// period, last block average, position, and in m_tuser a flag marking a
// freshly completed average.
// Config channel (cfg_*): stop limit, always ready; write it only while idle.
// Path: a word accepted into the input register is processed as it moves
// on into the output register, and shows on m_* from there.
// Throughput: one word per cycle while m_tready stays high; the input register
// frees as the output register loads, and the state registers update on that load.
// Stall: when m_tready is low the output word holds; the input register
// still takes one more word, then s_tready drops until the output drains.
// Reset (arst_n low): all counts, sums and the average clear to zero, the
// stop limit returns to 1000000 and both stream sides go empty.
module encoder_period_tachometer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ept_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] capture_value, [16] forward,
	                                                  // rest zero
	input  logic [1:0]                      s_tuser,  // [1:0] op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ept_pkg::OUT_DATA_W-1:0]  m_tdata,  // [21:0] period, [43:22] average_period,
	                                                  // [75:44] position, rest zero
	output logic [0:0]                      m_tuser,  // [0] average_new
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [19:0]                     cfg_data  // stop_limit
);

	ept_pkg::item_t   in_item;
	ept_pkg::item_t   item_s1;
	ept_pkg::result_t result;
	ept_pkg::result_t out_result;
	logic             valid_s1;
	logic             out_free;
	logic             take;

	assign in_item.op            = s_tuser;
	assign in_item.capture_value = s_tdata[15:0];
	assign in_item.forward       = s_tdata[16];

	assign cfg_ready = 1'b1;

	// item moves on when the output register has room
	assign take = valid_s1 && out_free;

	ept_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ept_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_limit (cfg_data),
		.step      (take),
		.item      (item_s1),
		.result    (result)
	);

	ept_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.result     (result),
		.free       (out_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = {4'b0, out_result.position, out_result.average_period,
		out_result.period};
	assign m_tuser = out_result.average_new;

endmodule

// ===== hdl/ept_in_reg.sv =====
module ept_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ept_pkg::item_t in_item,
	input  logic           take,
	output logic           valid_s1,
	output ept_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hdl/ept_datapath.sv =====
module ept_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ept_pkg::LIMIT_W-1:0]    cfg_limit,
	input  logic                           step,
	input  ept_pkg::item_t                 item,
	output ept_pkg::result_t               result
);

	logic [ept_pkg::LIMIT_W-1:0] stop_limit_q;
	logic [ept_pkg::RUN_W-1:0]   running_q;
	logic [ept_pkg::PER_W-1:0]   period_q;
	logic [ept_pkg::SUM_W-1:0]   sum_q;
	logic [ept_pkg::CNT_W-1:0]   count_q;
	logic [ept_pkg::PER_W-1:0]   average_q;
	logic [ept_pkg::POS_W-1:0]   position_q;

	logic [ept_pkg::RUN_W-1:0]   running_d;
	logic [ept_pkg::PER_W-1:0]   period_d;
	logic [ept_pkg::SUM_W-1:0]   sum_d;
	logic [ept_pkg::CNT_W-1:0]   count_d;
	logic [ept_pkg::PER_W-1:0]   average_d;
	logic [ept_pkg::POS_W-1:0]   position_d;
	logic [ept_pkg::POS_W-1:0]   position_out;
	logic                        fresh;

	logic [ept_pkg::PER_W-1:0]   run_ext;
	logic [ept_pkg::PER_W-1:0]   ovf_sum;
	logic [ept_pkg::PER_W-1:0]   limit_ext;
	logic                        ovf_hit;
	logic [ept_pkg::PER_W-1:0]   cap_period;
	logic [ept_pkg::RUN_W-1:0]   cap_running;
	logic [ept_pkg::SUM_W:0]     sum_ext;
	logic [ept_pkg::SUM_W:0]     per_ext;
	logic [ept_pkg::SUM_W:0]     sum_raw;
	logic [ept_pkg::SUM_W-1:0]   sum_sat;
	logic [ept_pkg::CNT_W-1:0]   count_inc;
	logic [ept_pkg::POS_W-1:0]   position_step;
	logic [ept_pkg::MAG_W-1:0]   mag;
	logic [ept_pkg::PROD_W-1:0]  prod;
	logic [ept_pkg::PER_W-1:0]   quot;
	logic [ept_pkg::PER_W-1:0]   avg_calc;

	// overflow: grow by timer span, clamp at the stop limit
	assign run_ext   = {running_q[ept_pkg::RUN_W-1], running_q};
	assign ovf_sum   = run_ext + ept_pkg::PER_W'(ept_pkg::TIMER_SPAN);
	assign limit_ext = ept_pkg::PER_W'(stop_limit_q);
	assign ovf_hit   = $signed(ovf_sum) >= $signed(limit_ext);

	// capture: new period and restart of running count
	assign cap_period  = run_ext + ept_pkg::PER_W'(item.capture_value);
	assign cap_running = ept_pkg::RUN_W'(0) - ept_pkg::RUN_W'(item.capture_value);

	// signed sum with saturation, one guard bit
	assign sum_ext = {sum_q[ept_pkg::SUM_W-1], sum_q};
	assign per_ext = {{(ept_pkg::SUM_W+1-ept_pkg::PER_W){cap_period[ept_pkg::PER_W-1]}},
		cap_period};
	assign sum_raw = item.forward ? sum_ext + per_ext : sum_ext - per_ext;

	always_comb begin
		if (sum_raw[ept_pkg::SUM_W] != sum_raw[ept_pkg::SUM_W-1]) begin
			sum_sat = sum_raw[ept_pkg::SUM_W] ? ept_pkg::SUM_MIN : ept_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_raw[ept_pkg::SUM_W-1:0];
		end
	end

	// truncating divide: magnitude times reciprocal, sign restored
	assign mag  = sum_sat[ept_pkg::SUM_W-1] ?
		ept_pkg::MAG_W'(0) - {sum_sat[ept_pkg::SUM_W-1], sum_sat} : {1'b0, sum_sat};
	assign prod = ept_pkg::PROD_W'(mag) * ept_pkg::PROD_W'(ept_pkg::RECIP);
	assign quot = prod[ept_pkg::DIV_K +: ept_pkg::PER_W];
	assign avg_calc = sum_sat[ept_pkg::SUM_W-1] ? ept_pkg::PER_W'(0) - quot : quot;

	assign count_inc     = count_q + ept_pkg::CNT_W'(1);
	assign position_step = item.forward ? position_q + ept_pkg::POS_W'(1)
		: position_q - ept_pkg::POS_W'(1);

	always_comb begin
		running_d    = running_q;
		period_d     = period_q;
		sum_d        = sum_q;
		count_d      = count_q;
		average_d    = average_q;
		position_d   = position_q;
		position_out = position_q;
		fresh        = 1'b0;
		case (ept_pkg::op_t'(item.op))
			ept_pkg::OP_OVERFLOW: begin
				if (ovf_hit) begin
					running_d = ept_pkg::RUN_W'(stop_limit_q);
					period_d  = limit_ext;
				end else begin
					running_d = ovf_sum[ept_pkg::RUN_W-1:0];
				end
			end
			ept_pkg::OP_CAPTURE: begin
				position_d   = position_step;
				position_out = position_step;
				period_d     = cap_period;
				running_d    = cap_running;
				if (count_inc >= ept_pkg::CNT_W'(ept_pkg::AVG_LEN)) begin
					average_d = avg_calc;
					count_d   = '0;
					sum_d     = '0;
					fresh     = 1'b1;
				end else begin
					count_d = count_inc;
					sum_d   = sum_sat;
				end
			end
			ept_pkg::OP_CLEAR: begin
				position_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_limit_q <= ept_pkg::STOP_LIMIT_RESET;
		end else if (cfg_we) begin
			stop_limit_q <= cfg_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= '0;
			period_q   <= '0;
			sum_q      <= '0;
			count_q    <= '0;
			average_q  <= '0;
			position_q <= '0;
		end else if (step) begin
			running_q  <= running_d;
			period_q   <= period_d;
			sum_q      <= sum_d;
			count_q    <= count_d;
			average_q  <= average_d;
			position_q <= position_d;
		end
	end

	assign result.period         = period_d;
	assign result.average_period = average_d;
	assign result.average_new    = fresh;
	assign result.position       = position_out;

endmodule

// ===== hdl/ept_out_reg.sv =====
module ept_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ept_pkg::result_t result,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output ept_pkg::result_t out_result
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_result <= result;
		end
	end

endmodule
